### rtl/fst_pkg.sv
package fst_pkg;

  // Shared serial divider geometry.
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = 7;

  // Shared serial multiplier geometry.
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = 64;
  localparam int MUL_CNT_W = 6;

  // Datapath widths. The clamped counter delta is at most (2^32-1)/10.
  localparam int DELTA_W = 29;
  localparam int STEP_W  = 24;
  localparam int ACC_W   = 25;
  localparam int SAT_W   = 20;

  // Constant divisor for the delta clamp.
  localparam logic [DIVISOR_W-1:0] CLAMP_DIV = 32'd10;

  // Command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_FREQ   = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  // Register reset values.
  localparam logic [31:0]       FREQ_RESET   = 32'd10000000;
  localparam logic              MODE_RESET   = 1'b0;
  localparam logic [STEP_W-1:0] TARGET_RESET = 24'd166666;
  localparam logic [SAT_W-1:0]  STEPS_SAT    = 20'hFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MAXD,
    ST_MAXD_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_CONV,
    ST_CONV_WAIT,
    ST_STEP,
    ST_SDIV_WAIT,
    ST_SMUL,
    ST_SMUL_WAIT,
    ST_COUNT,
    ST_MOD_WAIT,
    ST_OUT
  } fst_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIV_CNT_W-1:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   mcand;
    logic [MUL_B_W-1:0]   mplier;
    logic [MUL_CNT_W-1:0] iters;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic [MUL_P_W-1:0] product;
  } mul_rsp_t;

endpackage

### rtl/fst_div.sv
module fst_div (
  input  logic              clk,
  input  logic              rst,
  input  fst_pkg::div_req_t req,
  output fst_pkg::div_rsp_t rsp
);
  import fst_pkg::*;

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;

  logic [DIVISOR_W:0]    partial;
  logic [DIVISOR_W+1:0]  trial;
  logic                  borrow;

  // One restoring step: bring down the next dividend bit and try the divisor.
  // The divisor is held locally because the request is only valid at start.
  always_comb begin
    partial = {rem, quo[DIVIDEND_W-1]};
    trial   = {1'b0, partial} - {2'b00, dvsr};
    borrow  = trial[DIVISOR_W+1];
  end

  // The dividend arrives left aligned, so the quotient fills the low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.iters;
      quo  <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], ~borrow};
      rem <= borrow ? partial[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### rtl/fst_mul.sv
module fst_mul (
  input  logic              clk,
  input  logic              rst,
  input  fst_pkg::mul_req_t req,
  output fst_pkg::mul_rsp_t rsp
);
  import fst_pkg::*;

  logic [MUL_P_W-1:0]   mcand;
  logic [MUL_B_W-1:0]   mplier;
  logic [MUL_P_W-1:0]   prod;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;

  // Shift-and-add, one multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy   <= 1'b1;
      cnt    <= req.iters;
      mcand  <= MUL_P_W'(req.mcand);
      mplier <= req.mplier;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= {mcand[MUL_P_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MUL_B_W-1:1]};
      cnt    <= cnt - 1'b1;
      if (cnt == MUL_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy    = busy;
  assign rsp.product = prod;

endmodule

### rtl/frame_step_timer.sv
// Channel  | Handshake                | Word
// ---------+--------------------------+------------------------------------------------
// item     | item_valid / item_ready  | cmd, counter_value
// result   | result_valid / result_ready | step_ticks, total_ticks_out, frame_number,
//          |                          | steps_taken, frame_rate, second_passed
// cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A reset command goes from acceptance through the difference step straight to the
// result. A tick runs the clamp division, the multiply and the conversion division;
// in fixed mode it adds the step division and, when steps are taken, the step multiply,
// and a completed second adds the modulo division. The bit-serial divider, one quotient
// bit per cycle over up to 64 bits, does most of this work. The next word is accepted in
// the cycle after the result is loaded.
// Reset is synchronous and restores the registers and clears all timer state.
// One word is in flight at a time; a result waiting in the output register
// does not keep the next word from being accepted, but the following result
// waits in the output step until it is taken.
module frame_step_timer #(
  parameter int unsigned CANON_TICK_RATE = 10000000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       cmd,
  input  logic [63:0]                counter_value,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [fst_pkg::STEP_W-1:0] step_ticks,
  output logic [63:0]                total_ticks_out,
  output logic [31:0]                frame_number,
  output logic [fst_pkg::SAT_W-1:0]  steps_taken,
  output logic [31:0]                frame_rate,
  output logic                       second_passed,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import fst_pkg::*;

  localparam int TW   = $clog2(CANON_TICK_RATE + 1);
  localparam int PW   = DELTA_W + TW;
  localparam int SNAP = CANON_TICK_RATE / 4000;

  fst_state_t state, state_next;

  // Configuration registers.
  logic [31:0]       counter_frequency;
  logic              fixed_step_mode;
  logic [STEP_W-1:0] target_step_ticks;

  // Timer state.
  logic [63:0]       last_reading;
  logic [63:0]       total_sum;
  logic [STEP_W-1:0] leftover;
  logic [STEP_W-1:0] last_step;
  logic [31:0]       frames_total;
  logic [31:0]       frames_in_second;
  logic [31:0]       rate_held;
  logic [63:0]       second_accum;

  // Per-word working registers.
  logic              cmd_q;
  logic [63:0]       now_q;
  logic [63:0]       raw_q;
  logic [DELTA_W-1:0] delta_q;
  logic [STEP_W-1:0] conv_q;
  logic [ACC_W-1:0]  steps_q;
  logic              passed_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic [31:0]        freq_eff;
  logic [STEP_W-1:0]  target_eff;
  logic [DELTA_W-1:0] maxd;
  logic [STEP_W-1:0]  diff;
  logic [STEP_W-1:0]  snapped;
  logic [ACC_W-1:0]   acc;
  logic [31:0]        fis_inc;
  logic               second_done;

  fst_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fst_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;

  // Zero frequency and zero target behave as one.
  assign freq_eff   = (counter_frequency == '0) ? 32'd1 : counter_frequency;
  assign target_eff = (target_step_ticks == '0) ? STEP_W'(1) : target_step_ticks;

  // Clamp bound, fixed-mode snapping and leftover sum, frame count and second check.
  always_comb begin
    maxd    = div_rsp.quotient[DELTA_W-1:0];
    diff    = (conv_q > target_eff) ? (conv_q - target_eff) : (target_eff - conv_q);
    snapped = (32'(diff) < 32'(SNAP)) ? target_eff : conv_q;
    acc     = {1'b0, leftover} + {1'b0, snapped};
    fis_inc = frames_in_second + 32'(steps_q != '0);
    second_done = (second_accum >= 64'(freq_eff));
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_frequency <= FREQ_RESET;
      fixed_step_mode   <= MODE_RESET;
      target_step_ticks <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FREQ:   counter_frequency <= cfg_data;
        REG_MODE:   fixed_step_mode   <= cfg_data[0];
        REG_TARGET: target_step_ticks <= cfg_data[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (item_valid) state_next = ST_DIFF;
      ST_DIFF:      state_next = (cmd_q == CMD_RESET) ? ST_OUT : ST_MAXD;
      ST_MAXD:      state_next = ST_MAXD_WAIT;
      ST_MAXD_WAIT: if (!div_rsp.busy) state_next = ST_MUL;
      ST_MUL:       state_next = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (!mul_rsp.busy) state_next = ST_CONV;
      ST_CONV:      state_next = ST_CONV_WAIT;
      ST_CONV_WAIT: if (!div_rsp.busy) state_next = ST_STEP;
      ST_STEP:      state_next = fixed_step_mode ? ST_SDIV_WAIT : ST_COUNT;
      ST_SDIV_WAIT: begin
        if (!div_rsp.busy) begin
          state_next = (div_rsp.quotient[ACC_W-1:0] != '0) ? ST_SMUL : ST_COUNT;
        end
      end
      ST_SMUL:      state_next = ST_SMUL_WAIT;
      ST_SMUL_WAIT: if (!mul_rsp.busy) state_next = ST_COUNT;
      ST_COUNT:     state_next = second_done ? ST_MOD_WAIT : ST_OUT;
      ST_MOD_WAIT:  if (!div_rsp.busy) state_next = ST_OUT;
      ST_OUT:       if (!result_valid || result_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Requests to the shared serial units.
  always_comb begin
    div_req = '0;
    mul_req = '0;
    unique case (state)
      ST_MAXD: begin
        div_req.start    = 1'b1;
        div_req.dividend = {freq_eff, 32'd0};
        div_req.divisor  = CLAMP_DIV;
        div_req.iters    = DIV_CNT_W'(32);
      end
      ST_MUL: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MUL_A_W'(CANON_TICK_RATE);
        mul_req.mplier = MUL_B_W'(delta_q);
        mul_req.iters  = MUL_CNT_W'(DELTA_W);
      end
      ST_CONV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_rsp.product << (DIVIDEND_W - PW);
        div_req.divisor  = freq_eff;
        div_req.iters    = DIV_CNT_W'(PW);
      end
      ST_STEP: begin
        div_req.start    = fixed_step_mode;
        div_req.dividend = {acc, {(DIVIDEND_W-ACC_W){1'b0}}};
        div_req.divisor  = DIVISOR_W'(target_eff);
        div_req.iters    = DIV_CNT_W'(ACC_W);
      end
      ST_SMUL: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MUL_A_W'(target_eff);
        mul_req.mplier = MUL_B_W'(steps_q);
        mul_req.iters  = MUL_CNT_W'(ACC_W);
      end
      ST_COUNT: begin
        div_req.start    = second_done;
        div_req.dividend = second_accum;
        div_req.divisor  = freq_eff;
        div_req.iters    = DIV_CNT_W'(DIVIDEND_W);
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Timer state and per-word datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_reading     <= '0;
      total_sum        <= '0;
      leftover         <= '0;
      last_step        <= '0;
      frames_total     <= '0;
      frames_in_second <= '0;
      rate_held        <= '0;
      second_accum     <= '0;
      steps_q          <= '0;
      passed_q         <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cmd_q <= cmd;
            now_q <= counter_value;
          end
        end
        ST_DIFF: begin
          steps_q  <= '0;
          passed_q <= 1'b0;
          last_reading <= now_q;
          if (cmd_q == CMD_RESET) begin
            leftover         <= '0;
            rate_held        <= '0;
            frames_in_second <= '0;
            second_accum     <= '0;
          end else begin
            raw_q        <= now_q - last_reading;
            second_accum <= second_accum + (now_q - last_reading);
          end
        end
        ST_MAXD_WAIT: begin
          if (!div_rsp.busy) begin
            delta_q <= (raw_q > 64'(maxd)) ? maxd : raw_q[DELTA_W-1:0];
          end
        end
        ST_CONV_WAIT: begin
          if (!div_rsp.busy) begin
            conv_q <= div_rsp.quotient[STEP_W-1:0];
          end
        end
        ST_STEP: begin
          if (!fixed_step_mode) begin
            last_step    <= conv_q;
            total_sum    <= total_sum + 64'(conv_q);
            leftover     <= '0;
            frames_total <= frames_total + 32'd1;
            steps_q      <= ACC_W'(1);
          end
        end
        ST_SDIV_WAIT: begin
          if (!div_rsp.busy) begin
            steps_q  <= div_rsp.quotient[ACC_W-1:0];
            leftover <= div_rsp.remainder[STEP_W-1:0];
            if (div_rsp.quotient[ACC_W-1:0] != '0) begin
              last_step    <= target_eff;
              frames_total <= frames_total + 32'(div_rsp.quotient[ACC_W-1:0]);
            end
          end
        end
        ST_SMUL_WAIT: begin
          if (!mul_rsp.busy) begin
            total_sum <= total_sum + mul_rsp.product;
          end
        end
        ST_COUNT: begin
          if (second_done) begin
            rate_held        <= fis_inc;
            frames_in_second <= '0;
            passed_q         <= 1'b1;
          end else begin
            frames_in_second <= fis_inc;
          end
        end
        ST_MOD_WAIT: begin
          if (!div_rsp.busy) begin
            second_accum <= 64'(div_rsp.remainder);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register; frees the sequencer as soon as the word is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && (!result_valid || result_ready)) begin
      result_valid    <= 1'b1;
      step_ticks      <= last_step;
      total_ticks_out <= total_sum;
      frame_number    <= frames_total;
      steps_taken     <= (steps_q > ACC_W'(STEPS_SAT)) ? STEPS_SAT : steps_q[SAT_W-1:0];
      frame_rate      <= rate_held;
      second_passed   <= passed_q;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // An accepted word always starts with the difference step.
  a_accept_to_diff: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == ST_DIFF)
    else $error("accepted word did not enter the difference step");

  // The shared divider is never restarted while it is still iterating.
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The shared multiplier is never restarted while it is still iterating.
  a_mul_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // After the step division the leftover is below the target step.
  a_leftover_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SDIV_WAIT && !div_rsp.busy |=> leftover < target_eff)
    else $error("leftover not below target after step division");

endmodule
